@@ hw/rtl/srsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot ring status pool package
// Shared constants, codes and types of the slot ring status pool.
// ----------------------------------------------------------------------------
package srsp_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY   = 3'd0,
    ACT_ACQUIRE = 3'd1,
    ACT_CANCEL  = 3'd2,
    ACT_FINISH  = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_CLEAR   = 3'd5
  } srsp_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OPEN = 2'd0,
    STATUS_BUSY = 2'd1,
    STATUS_DONE = 2'd2
  } srsp_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HEAD,
    ST_TAIL,
    ST_FINAL
  } srsp_state_e;

  // Access request from the sequencer to the status store
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    srsp_status_e      wr_data;
    logic              clear;
  } srsp_mem_req_t;

endpackage

@@ hw/rtl/srsp_req_if.sv @@
// ----------------------------------------------------------------------------
// Slot ring request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface srsp_req_if;
  import srsp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output action, output slot_index, input ready);
  modport sink   (input valid, input action, input slot_index, output ready);
endinterface

@@ hw/rtl/srsp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Slot ring result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface srsp_rsp_if;
  import srsp_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic [IDX_W-1:0] granted_slot;
  logic             open_available;
  logic [IDX_W-1:0] finished_slot;
  logic             finished_available;

  modport source (output valid, output accepted, output granted_slot,
                  output open_available, output finished_slot,
                  output finished_available, input ready);
  modport sink   (input valid, input accepted, input granted_slot,
                  input open_available, input finished_slot,
                  input finished_available, output ready);
endinterface

@@ hw/rtl/srsp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/srsp_store.sv @@
// ----------------------------------------------------------------------------
// Slot status store
// Status RAM with a valid bit per slot; a slot never written reads as open.
// ----------------------------------------------------------------------------
module srsp_store
  import srsp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srsp_mem_req_t req_i,
  output srsp_status_e  rd_status_o
);

  logic [NUM_SLOTS-1:0] valid_q;
  logic                 rd_valid_q;
  logic [STATUS_W-1:0]  rdata;

  srsp_ram #(
    .WIDTH (STATUS_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_status_o = rd_valid_q ? srsp_status_e'(rdata) : STATUS_OPEN;

endmodule

@@ hw/rtl/srsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot ring sequencer
// Holds head, tail and ring size; steps each request through the store.
// ----------------------------------------------------------------------------
module srsp_ctrl
  import srsp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  srsp_req_if.sink             req_i,
  srsp_rsp_if.source           rsp_o,
  output srsp_mem_req_t        mem_req_o,
  input  srsp_status_e         rd_status_i
);

  typedef struct packed {
    logic              acc;
    logic [SLOT_W-1:0] grant;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    srsp_status_e      wr_data;
    logic              clear;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } exec_t;

  srsp_state_e       state_q, state_d;
  logic [CFG_W-1:0]  slots_used_q;
  logic [SLOT_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0]  m_q;
  logic [ACT_W-1:0]  act_q;
  logic [SLOT_W-1:0] idx_q;
  logic              idx_ok_q;
  logic              acc_q;
  logic [SLOT_W-1:0] grant_q;
  logic              open_q;

  logic              out_valid_q;
  logic              out_acc_q;
  logic [IDX_W-1:0]  out_grant_q;
  logic              out_open_q;
  logic [IDX_W-1:0]  out_tail_q;
  logic              out_done_q;

  logic [CNT_W-1:0]  ring_m;
  logic [SLOT_W-1:0] head_norm, tail_norm;
  logic              accept;
  logic              out_load;
  exec_t             exec;

  // Clamp the ring size into 1..NUM_SLOTS
  always_comb begin
    if (slots_used_q == '0) begin
      ring_m = CNT_W'(1);
    end else if (slots_used_q > CFG_W'(NUM_SLOTS)) begin
      ring_m = CNT_W'(NUM_SLOTS);
    end else begin
      ring_m = CNT_W'(slots_used_q);
    end
  end

  assign head_norm = (CNT_W'(head_q) >= ring_m) ? '0 : head_q;
  assign tail_norm = (CNT_W'(tail_q) >= ring_m) ? '0 : tail_q;
  assign accept    = req_i.valid && req_i.ready;
  assign out_load  = (state_q == ST_FINAL) && (!out_valid_q || rsp_o.ready);

  // Decide the request from the target slot status
  always_comb begin
    exec         = '0;
    exec.wr_data = STATUS_OPEN;
    exec.head    = head_q;
    exec.tail    = tail_q;
    case (act_q)
      ACT_QUERY: begin
        exec.acc = 1'b1;
      end
      ACT_ACQUIRE: begin
        if (rd_status_i == STATUS_OPEN) begin
          exec.acc     = 1'b1;
          exec.grant   = head_q;
          exec.wr_en   = 1'b1;
          exec.wr_addr = head_q;
          exec.wr_data = STATUS_BUSY;
          exec.head    = (CNT_W'(head_q) + CNT_W'(1) == m_q) ? '0 : head_q + SLOT_W'(1);
        end
      end
      ACT_CANCEL: begin
        if (idx_ok_q && rd_status_i == STATUS_BUSY) begin
          exec.acc     = 1'b1;
          exec.wr_en   = 1'b1;
          exec.wr_addr = idx_q;
          exec.wr_data = STATUS_OPEN;
          exec.head    = (head_q == '0) ? SLOT_W'(m_q - CNT_W'(1)) : head_q - SLOT_W'(1);
        end
      end
      ACT_FINISH: begin
        if (idx_ok_q && rd_status_i == STATUS_BUSY) begin
          exec.acc     = 1'b1;
          exec.wr_en   = 1'b1;
          exec.wr_addr = idx_q;
          exec.wr_data = STATUS_DONE;
        end
      end
      ACT_RELEASE: begin
        if (idx_ok_q && rd_status_i == STATUS_DONE) begin
          exec.acc     = 1'b1;
          exec.wr_en   = 1'b1;
          exec.wr_addr = idx_q;
          exec.wr_data = STATUS_OPEN;
          exec.tail    = (CNT_W'(tail_q) + CNT_W'(1) == m_q) ? '0 : tail_q + SLOT_W'(1);
        end
      end
      ACT_CLEAR: begin
        exec.acc   = 1'b1;
        exec.clear = 1'b1;
        exec.head  = '0;
        exec.tail  = '0;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_HEAD;
      ST_HEAD:  state_d = ST_TAIL;
      ST_TAIL:  state_d = ST_FINAL;
      ST_FINAL: if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs: store accesses and request ready
  always_comb begin
    mem_req_o         = '0;
    mem_req_o.wr_data = STATUS_OPEN;
    req_i.ready       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready       = 1'b1;
        mem_req_o.rd_en   = accept;
        mem_req_o.rd_addr = (req_i.action == ACT_ACQUIRE) ? head_norm
                                                          : SLOT_W'(req_i.slot_index);
      end
      ST_EXEC: begin
        mem_req_o.wr_en   = exec.wr_en;
        mem_req_o.wr_addr = exec.wr_addr;
        mem_req_o.wr_data = exec.wr_data;
        mem_req_o.clear   = exec.clear;
      end
      ST_HEAD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = head_q;
      end
      ST_TAIL: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = tail_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slots_used_q <= CFG_W'(NUM_SLOTS);
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        slots_used_q <= cfg_wdata_i;
      end
      if (state_q == ST_IDLE && accept) begin
        head_q <= head_norm;
        tail_q <= tail_norm;
      end else if (state_q == ST_EXEC) begin
        head_q <= exec.head;
        tail_q <= exec.tail;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      m_q      <= ring_m;
      act_q    <= req_i.action;
      idx_q    <= SLOT_W'(req_i.slot_index);
      idx_ok_q <= CNT_W'(req_i.slot_index) < ring_m;
    end
    if (state_q == ST_EXEC) begin
      acc_q   <= exec.acc;
      grant_q <= exec.grant;
    end
    if (state_q == ST_TAIL) begin
      open_q <= (rd_status_i == STATUS_OPEN);
    end
    if (out_load) begin
      out_acc_q   <= acc_q;
      out_grant_q <= IDX_W'(grant_q);
      out_open_q  <= open_q;
      out_tail_q  <= IDX_W'(tail_q);
      out_done_q  <= (rd_status_i == STATUS_DONE);
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.accepted           = out_acc_q;
  assign rsp_o.granted_slot       = out_grant_q;
  assign rsp_o.open_available     = out_open_q;
  assign rsp_o.finished_slot      = out_tail_q;
  assign rsp_o.finished_available = out_done_q;

endmodule

@@ hw/rtl/slot_ring_status_pool_top.sv @@
// ----------------------------------------------------------------------------
// Slot ring status pool
// Ring of slots (open, in progress, finished) with head and tail pointers.
// ----------------------------------------------------------------------------
// Each request item (query, acquire, cancel, finish, release, clear all)
// yields exactly one result item with the acceptance flag, the granted slot,
// whether the head slot is open and whether the tail slot is finished. Slot
// status lives in a 16-entry RAM with one read and one write port. Between
// accept and a loaded result, a request makes three dependent reads of
// that single read port (target slot, then the new head, then the new tail)
// plus the write-back. The next item is taken in the cycle after the result
// is loaded, so the block takes no new item while one is in flight. The
// result sits in an output register, and a stalled result side holds the
// block only once the next result is ready. Reset and clear all take effect
// at once through per-slot valid bits: no clearing pass. The ring size
// register is to be written only while the block is idle, which the block
// does not enforce; zero acts as one and values above sixteen as sixteen.
// ----------------------------------------------------------------------------
module slot_ring_status_pool_top
  import srsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  srsp_req_if.sink         req_i,
  srsp_rsp_if.source       rsp_o
);

  srsp_mem_req_t mem_req;
  srsp_status_e  rd_status;

  // Sequencer: pointers, ring size and result register
  srsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .rd_status_i (rd_status)
  );

  // Slot status storage
  srsp_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rd_status_o (rd_status)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot ring status pool testbench
// Drives request items into the slot ring pool and checks every result item
// against a cycle-free model of the ring kept inside this bench. Directed
// cases come first, then random phases over several ring sizes, an output
// stall long enough to back up the input, a full pause of the sender, and a
// final stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import srsp_pkg::*;

  // Expected content of one result item
  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] granted_slot;
    logic             open_available;
    logic [IDX_W-1:0] finished_slot;
    logic             finished_available;
  } ring_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  srsp_req_if req_ch ();
  srsp_rsp_if rsp_ch ();

  slot_ring_status_pool_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // Ring model: slot status, head and tail, and the ring size register
  srsp_status_e     slot_stat [NUM_SLOTS];
  int unsigned      head_q;
  int unsigned      tail_q;
  logic [CFG_W-1:0] ring_size_reg;

  // Results predicted at request accept, oldest first
  ring_result_t pending_results [$];

  int unsigned error_count  = 0;
  int unsigned result_count = 0;

  // Idling and stall controls
  bit idle_en      = 1'b1;
  bit hold_request = 1'b0;
  bit long_hold    = 1'b0;
  int unsigned stall_left = 0;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The slowest legal run ends well before this watchdog fires.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Ring model
  // --------------------------------------------------------------------------
  // Clamp the size register into 1..NUM_SLOTS.
  function automatic int unsigned ring_modulus();
    if (ring_size_reg == 0) return 1;
    if (ring_size_reg > NUM_SLOTS) return NUM_SLOTS;
    return ring_size_reg;
  endfunction

  function automatic void clear_ring();
    foreach (slot_stat[i]) slot_stat[i] = STATUS_OPEN;
    head_q = 0;
    tail_q = 0;
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic ring_result_t predict_step(logic [ACT_W-1:0] act,
                                                logic [IDX_W-1:0] idx);
    ring_result_t r;
    int unsigned  m;
    logic         idx_ok;
    m = ring_modulus();
    r = '0;
    idx_ok = (idx < m);
    // A pointer left past the ring after a shrink reads as zero.
    if (head_q >= m) head_q = 0;
    if (tail_q >= m) tail_q = 0;
    case (act)
      ACT_QUERY: begin
        r.accepted = 1'b1;
      end
      ACT_ACQUIRE: begin
        if (slot_stat[head_q] == STATUS_OPEN) begin
          r.granted_slot = IDX_W'(head_q);
          slot_stat[head_q] = STATUS_BUSY;
          head_q = (head_q + 1) % m;
          r.accepted = 1'b1;
        end
      end
      ACT_CANCEL: begin
        if (idx_ok && slot_stat[idx] == STATUS_BUSY) begin
          slot_stat[idx] = STATUS_OPEN;
          head_q = (head_q + m - 1) % m;
          r.accepted = 1'b1;
        end
      end
      ACT_FINISH: begin
        if (idx_ok && slot_stat[idx] == STATUS_BUSY) begin
          slot_stat[idx] = STATUS_DONE;
          r.accepted = 1'b1;
        end
      end
      ACT_RELEASE: begin
        // Any finished slot may go back; the tail steps regardless.
        if (idx_ok && slot_stat[idx] == STATUS_DONE) begin
          slot_stat[idx] = STATUS_OPEN;
          tail_q = (tail_q + 1) % m;
          r.accepted = 1'b1;
        end
      end
      ACT_CLEAR: begin
        clear_ring();
        r.accepted = 1'b1;
      end
      default: begin
        // Unused codes leave everything alone and are refused.
      end
    endcase
    r.open_available     = (slot_stat[head_q] == STATUS_OPEN);
    r.finished_slot      = IDX_W'(tail_q);
    r.finished_available = (slot_stat[tail_q] == STATUS_DONE);
    return r;
  endfunction

  // Pick a slot inside the ring in the wanted state, or any slot if none.
  function automatic logic [IDX_W-1:0] pick_slot(srsp_status_e want);
    int unsigned      m;
    logic [IDX_W-1:0] hits [$];
    m = ring_modulus();
    for (int i = 0; i < m; i++) begin
      if (slot_stat[i] == want) hits.push_back(IDX_W'(i));
    end
    if (hits.size() == 0) return IDX_W'($urandom_range(0, m - 1));
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, then decide ready
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [IDX_W-1:0] got,
                                 logic [IDX_W-1:0] want);
    $display("error: result %0d %s: got %0d, expected %0d",
             result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    ring_result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("arrived with none expected", '0, '0);
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.accepted !== want.accepted)
      report_mismatch("accepted", IDX_W'(rsp_ch.accepted),
                      IDX_W'(want.accepted));
    if (rsp_ch.granted_slot !== want.granted_slot)
      report_mismatch("granted_slot", rsp_ch.granted_slot, want.granted_slot);
    if (rsp_ch.open_available !== want.open_available)
      report_mismatch("open_available", IDX_W'(rsp_ch.open_available),
                      IDX_W'(want.open_available));
    if (rsp_ch.finished_slot !== want.finished_slot)
      report_mismatch("finished_slot", rsp_ch.finished_slot,
                      want.finished_slot);
    if (rsp_ch.finished_available !== want.finished_available)
      report_mismatch("finished_available", IDX_W'(rsp_ch.finished_available),
                      IDX_W'(want.finished_available));
  endtask

  // Sample the handshake as it stood before this edge, then set ready for
  // the next cycle: long hold first, then a running burst, then maybe a new
  // burst of idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hold the result side off for a long stretch on request, counted here.
  initial begin
    forever begin
      wait (hold_request);
      long_hold = 1'b1;
      repeat (300) @(posedge clk_i);
      long_hold    = 1'b0;
      hold_request = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one item, optionally after an idle burst, and hold it until taken.
  // Predict its result at the accepting edge.
  task automatic send_request(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.slot_index <= idx;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    pending_results.push_back(predict_step(act, idx));
  endtask

  // Drop valid and wait until every predicted result has come back, then
  // let the pipeline settle.
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the ring size only with the block idle.
  task automatic write_ring_size(logic [CFG_W-1:0] value);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    ring_size_reg  = value;
  endtask

  // One random item: mostly well-formed ring traffic aimed at slots in the
  // right state, some clears and queries, the rest raw noise.
  task automatic send_random_op();
    int unsigned      roll;
    int unsigned      m;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    m    = ring_modulus();
    if (roll < 26) begin
      act = ACT_ACQUIRE;
      idx = IDX_W'($urandom);
    end else if (roll < 46) begin
      act = ACT_FINISH;
      idx = pick_slot(STATUS_BUSY);
    end else if (roll < 56) begin
      act = ACT_RELEASE;
      idx = (tail_q >= m) ? '0 : IDX_W'(tail_q);
    end else if (roll < 64) begin
      act = ACT_RELEASE;
      idx = pick_slot(STATUS_DONE);
    end else if (roll < 76) begin
      act = ACT_CANCEL;
      idx = pick_slot(STATUS_BUSY);
    end else if (roll < 82) begin
      act = ACT_QUERY;
      idx = IDX_W'($urandom);
    end else if (roll < 85) begin
      act = ACT_CLEAR;
      idx = IDX_W'($urandom);
    end else begin
      act = ACT_W'($urandom_range(0, 7));
      idx = IDX_W'($urandom_range(0, 15));
    end
    send_request(act, idx);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every operation on the full ring, refusals for wrong slot state, and
  // the unused action codes.
  task automatic test_basic_ops();
    send_request(ACT_QUERY, 4'd0);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_FINISH, 4'd0);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_CANCEL, 4'd1);
    send_request(ACT_CANCEL, 4'd1);      // slot already open
    send_request(ACT_CANCEL, 4'd0);      // slot finished, not in progress
    send_request(ACT_RELEASE, 4'd0);
    send_request(ACT_RELEASE, 4'd0);     // slot no longer finished
    send_request(3'd6, 4'd15);
    send_request(3'd7, 4'd0);
    send_request(ACT_ACQUIRE, 4'd15);
    send_request(ACT_CLEAR, 4'd15);
    send_request(ACT_QUERY, 4'd15);
  endtask

  // Small rings: full ring, head wrapping back past zero, indices past the
  // ring, release away from the tail, pointers left past a shrunk ring and
  // the clamped sizes at both ends.
  task automatic test_wrap_and_shrink();
    write_ring_size(5'd4);
    repeat (4) send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_ACQUIRE, 4'd0);     // ring full
    send_request(ACT_CANCEL, 4'd3);      // head steps back from 0 to 3
    send_request(ACT_FINISH, 4'd5);      // past the ring
    send_request(ACT_FINISH, 4'd2);
    send_request(ACT_RELEASE, 4'd2);     // not the tail, still accepted
    write_ring_size(5'd16);
    repeat (6) send_request(ACT_ACQUIRE, 4'd0);
    write_ring_size(5'd4);               // head now sits past the ring
    send_request(ACT_QUERY, 4'd0);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_CLEAR, 4'd0);
    write_ring_size(5'd0);               // acts as a one-slot ring
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_FINISH, 4'd0);
    send_request(ACT_RELEASE, 4'd0);
    send_request(ACT_RELEASE, 4'd15);
    write_ring_size(5'd31);              // acts as sixteen
    send_request(ACT_ACQUIRE, 4'd0);
    send_request(ACT_QUERY, 4'd15);
  endtask

  // Random traffic over a series of ring sizes, extremes included.
  task automatic test_random_sizes();
    logic [CFG_W-1:0] sizes [$];
    sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd12,
              CFG_W'($urandom_range(1, 16))};
    foreach (sizes[s]) begin
      write_ring_size(sizes[s]);
      repeat (150) send_random_op();
    end
  endtask

  // Block the result side long enough that the block backs up and refuses
  // new items while the sender keeps offering.
  task automatic test_output_stall();
    write_ring_size(5'd8);
    hold_request = 1'b1;
    repeat (80) send_random_op();
  endtask

  // Pause the sender until every result is back, then carry on.
  task automatic test_sender_pause();
    repeat (60) send_random_op();
    wait_all_results();
    repeat (60) send_random_op();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_no_idle();
    write_ring_size(5'd16);
    idle_en = 1'b0;
    repeat (350) send_random_op();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_ch.valid      = 1'b0;
    req_ch.action     = '0;
    req_ch.slot_index = '0;
    rsp_ch.ready      = 1'b0;
    ring_size_reg     = CFG_W'(NUM_SLOTS);
    clear_ring();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_wrap_and_shrink();
    test_random_sizes();
    test_output_stall();
    test_sender_pause();
    test_no_idle();

    // Drain, then give any stray result time to show up.
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
